/* hdl/hrsd_pkg.sv */
// ----------------------------------------------------------------------------
// hrsd_pkg
// Shared types, codes and helpers of the hex record stream decoder.
// ----------------------------------------------------------------------------
package hrsd_pkg;

	// characters of the record syntax
	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	// 'A' minus ten
	localparam logic [7:0] CHAR_ALPHA_BIAS = 8'h37;

	// record types with an effect
	localparam logic [7:0] REC_EOF      = 8'h01;
	localparam logic [7:0] REC_EXT_SEG  = 8'h02;
	localparam logic [7:0] REC_EXT_LIN  = 8'h04;

	// result kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// record end status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NO_COLON  = 2'd1;
	localparam logic [1:0] STATUS_BAD_CSUM  = 2'd2;

	// parse phase, one-hot
	typedef enum logic [5:0] {
		PH_WAIT = 6'b000001,
		PH_HDR  = 6'b000010,
		PH_DATA = 6'b000100,
		PH_CSUM = 6'b001000,
		PH_SKIP = 6'b010000,
		PH_HALT = 6'b100000
	} phase_t;

	// one result item
	typedef struct packed {
		logic        kind;
		logic [7:0]  byte_value;
		logic [31:0] byte_address;
		logic [7:0]  record_type;
		logic [7:0]  record_length;
		logic [15:0] record_offset;
		logic [1:0]  status;
		logic        end_of_file;
	} result_t;

	// hex digit to nibble, no validation
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] diff;
		if (c <= CHAR_NINE) begin
			diff = c - CHAR_ZERO;
		end else begin
			diff = c - CHAR_ALPHA_BIAS;
		end
		return diff[3:0];
	endfunction

endpackage

/* hdl/hrsd_parser.sv */
// ----------------------------------------------------------------------------
// hrsd_parser
// Record parse state and per-character result logic, one character a cycle.
// ----------------------------------------------------------------------------
module hrsd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       character,
	output logic             res_valid,
	output hrsd_pkg::result_t res
);
	import hrsd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  high_nibble_q, high_nibble_d;
	logic        toggle_q, toggle_d;
	logic [1:0]  hdr_index_q, hdr_index_d;
	logic [7:0]  length_q, length_d;
	logic [15:0] offset_q, offset_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  data_index_q, data_index_d;
	logic [7:0]  first_byte_q, first_byte_d;
	logic [7:0]  second_byte_q, second_byte_d;
	logic [31:0] base_q, base_d;

	logic [3:0]  nib;
	logic [7:0]  byte_full;
	logic [7:0]  sum_next;
	logic [7:0]  index_next;
	logic [15:0] word;

	assign nib        = hex_nibble(character);
	assign byte_full  = {high_nibble_q, nib};
	assign sum_next   = sum_q + byte_full;
	assign index_next = data_index_q + 8'd1;
	assign word       = {first_byte_q, second_byte_q};

	// next state and result for the accepted character
	always_comb begin
		phase_d       = phase_q;
		high_nibble_d = high_nibble_q;
		toggle_d      = toggle_q;
		hdr_index_d   = hdr_index_q;
		length_d      = length_q;
		offset_d      = offset_q;
		type_d        = type_q;
		sum_d         = sum_q;
		data_index_d  = data_index_q;
		first_byte_d  = first_byte_q;
		second_byte_d = second_byte_q;
		base_d        = base_q;
		res_valid     = 1'b0;
		res           = '0;
		if (accept) begin
			unique case (phase_q)
				PH_WAIT: begin
					if (character != CHAR_COLON) begin
						res_valid  = 1'b1;
						res.kind   = KIND_END;
						res.status = STATUS_NO_COLON;
						phase_d    = PH_HALT;
					end else begin
						sum_d         = '0;
						toggle_d      = 1'b0;
						high_nibble_d = '0;
						hdr_index_d   = '0;
						length_d      = '0;
						offset_d      = '0;
						type_d        = '0;
						data_index_d  = '0;
						first_byte_d  = '0;
						second_byte_d = '0;
						phase_d       = PH_HDR;
					end
				end
				PH_SKIP: begin
					if (character == CHAR_NEWLINE) begin
						phase_d = PH_WAIT;
					end
				end
				PH_HALT: begin
					phase_d = PH_HALT;
				end
				PH_HDR, PH_DATA, PH_CSUM: begin
					if (!toggle_q) begin
						// first digit of a pair
						high_nibble_d = nib;
						toggle_d      = 1'b1;
					end else begin
						toggle_d = 1'b0;
						sum_d    = sum_next;
						if (phase_q == PH_HDR) begin
							// header bytes: length, offset high, offset low, type
							unique case (hdr_index_q)
								2'd0:    length_d = byte_full;
								2'd1:    offset_d = {byte_full, offset_q[7:0]};
								2'd2:    offset_d = {offset_q[15:8], byte_full};
								default: type_d   = byte_full;
							endcase
							hdr_index_d = hdr_index_q + 2'd1;
							if (hdr_index_q == 2'd3) begin
								phase_d = (length_q != 8'd0) ? PH_DATA : PH_CSUM;
							end
						end else if (phase_q == PH_DATA) begin
							// data byte out with absolute address
							if (data_index_q == 8'd0) begin
								first_byte_d = byte_full;
							end else if (data_index_q == 8'd1) begin
								second_byte_d = byte_full;
							end
							res_valid         = 1'b1;
							res.kind          = KIND_DATA;
							res.byte_value    = byte_full;
							res.byte_address  = base_q + {16'd0, offset_q}
								+ {24'd0, data_index_q};
							res.record_type   = type_q;
							res.record_length = length_q;
							res.record_offset = offset_q;
							data_index_d      = index_next;
							if (index_next == length_q) begin
								phase_d = PH_CSUM;
							end
						end else begin
							// checksum byte closes the record
							res_valid         = 1'b1;
							res.kind          = KIND_END;
							res.record_type   = type_q;
							res.record_length = length_q;
							res.record_offset = offset_q;
							phase_d           = PH_SKIP;
							if (sum_next != 8'd0) begin
								res.status = STATUS_BAD_CSUM;
								phase_d    = PH_HALT;
							end else if (type_q == REC_EOF) begin
								res.end_of_file = 1'b1;
								phase_d         = PH_HALT;
							end else if (type_q == REC_EXT_SEG) begin
								base_d = {12'd0, word, 4'd0};
							end else if (type_q == REC_EXT_LIN) begin
								base_d = {word, 16'd0};
							end
						end
					end
				end
				default: begin
					phase_d = PH_WAIT;
				end
			endcase
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_WAIT;
			high_nibble_q <= '0;
			toggle_q      <= 1'b0;
			hdr_index_q   <= '0;
			length_q      <= '0;
			offset_q      <= '0;
			type_q        <= '0;
			sum_q         <= '0;
			data_index_q  <= '0;
			first_byte_q  <= '0;
			second_byte_q <= '0;
			base_q        <= '0;
		end else begin
			phase_q       <= phase_d;
			high_nibble_q <= high_nibble_d;
			toggle_q      <= toggle_d;
			hdr_index_q   <= hdr_index_d;
			length_q      <= length_d;
			offset_q      <= offset_d;
			type_q        <= type_d;
			sum_q         <= sum_d;
			data_index_q  <= data_index_d;
			first_byte_q  <= first_byte_d;
			second_byte_q <= second_byte_d;
			base_q        <= base_d;
		end
	end

	// halt is sticky until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("parser left halt");

	// a missing colon halts the block
	a_no_colon_halts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == STATUS_NO_COLON |=> phase_q == PH_HALT)
		else $error("missing colon did not halt");

	// end of file only on a clean record end
	a_eof_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.end_of_file |-> res.kind == KIND_END && res.status == STATUS_OK)
		else $error("end of file on a bad result");

endmodule

/* hdl/hrsd_skid.sv */
// ----------------------------------------------------------------------------
// hrsd_skid
// Two-entry output buffer: result register plus skid register.
// ----------------------------------------------------------------------------
module hrsd_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hrsd_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output hrsd_pkg::result_t out_data
);
	import hrsd_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// occupancy control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	// skid entry is only used behind a held result
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry without result entry");

	// a request arriving at a stalled result lands in the skid entry
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push && out_valid_q && out_stall |=> skid_valid_q)
		else $error("request lost at stalled output");

endmodule

/* hdl/hex_record_stream_decoder.sv */
// ----------------------------------------------------------------------------
// hex_record_stream_decoder
// Streaming decoder of hex records, one ASCII character per request.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle unless stalled and updates
// its record parse state in the same cycle. A data byte or record end result
// is written into a two-entry output buffer at the edge that takes its
// character, and it shows at the output once the results ahead of it have
// been taken. The input stalls only while both output entries hold results,
// so with a free-running output the block sustains one character every
// cycle. Missing colon, checksum mismatch and a valid end-of-file record
// halt the block until reset; a halted block accepts and ignores characters.
module hex_record_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  byte_value,
	output logic [31:0] byte_address,
	output logic [7:0]  record_type,
	output logic [7:0]  record_length,
	output logic [15:0] record_offset,
	output logic [1:0]  status,
	output logic        end_of_file
);
	import hrsd_pkg::*;

	logic    accept;
	logic    res_valid;
	logic    buf_full;
	result_t res;
	result_t out_data;

	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	// character parser
	hrsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.character (character),
		.res_valid (res_valid),
		.res       (res)
	);

	// result buffer
	hrsd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// result fields
	assign kind          = out_data.kind;
	assign byte_value    = out_data.byte_value;
	assign byte_address  = out_data.byte_address;
	assign record_type   = out_data.record_type;
	assign record_length = out_data.record_length;
	assign record_offset = out_data.record_offset;
	assign status        = out_data.status;
	assign end_of_file   = out_data.end_of_file;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_stream_decoder testbench
// Feeds hex record text one character per request and checks every data byte
// and record end against a predictor that parses the same text. Directed
// records come first, then random records with valid checksums and skip
// noise, and the run closes with one halting case picked at random.
// ----------------------------------------------------------------------------
module testbench;
	import hrsd_pkg::*;

	// record types that only matter to the stimulus
	localparam logic [7:0] REC_DATA      = 8'h00;
	localparam logic [7:0] REC_START_SEG = 8'h03;
	localparam logic [7:0] REC_START_LIN = 8'h05;
	localparam logic [7:0] REC_UNKNOWN   = 8'hFF;
	localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
	localparam logic [7:0] CHAR_RETURN   = 8'h0D;

	// idle schemes, rotated through the run
	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	// closing cases, each halts the block
	localparam int CLOSE_NO_COLON = 0;
	localparam int CLOSE_BAD_CSUM = 1;
	localparam int CLOSE_EOF      = 2;

	class hex_decode_scoreboard;
		phase_t      phase;
		logic [3:0]  high_nib;
		bit          have_high;
		logic [1:0]  hdr_idx;
		logic [7:0]  rec_len;
		logic [15:0] rec_off;
		logic [7:0]  rec_type;
		logic [7:0]  line_sum;
		logic [7:0]  data_idx;
		logic [7:0]  word_hi;
		logic [7:0]  word_lo;
		logic [31:0] load_base;
		result_t     decoded_queue[$];
		int unsigned mismatches;
		int unsigned chars_taken;
		int unsigned bytes_seen;
		int unsigned ends_seen;

		function new();
			phase = PH_WAIT;
			high_nib = '0;
			have_high = 1'b0;
			hdr_idx = '0;
			rec_len = '0;
			rec_off = '0;
			rec_type = '0;
			line_sum = '0;
			data_idx = '0;
			word_hi = '0;
			word_lo = '0;
			load_base = '0;
			mismatches = 0;
			chars_taken = 0;
			bytes_seen = 0;
			ends_seen = 0;
		endfunction

		// unchecked digit conversion, wraps to four bits
		function logic [3:0] digit_value(logic [7:0] c);
			logic [7:0] v;
			v = (c > CHAR_NINE) ? c + 8'd10 - CHAR_UPPER_A : c - CHAR_ZERO;
			return v[3:0];
		endfunction

		function void report(string msg);
			if (mismatches < 40) begin
				$display("mismatch: %s", msg);
			end
			mismatches++;
		endfunction

		// advance the parse by one accepted character
		function void take_character(logic [7:0] c);
			result_t    r;
			logic [7:0] b;
			logic [3:0] nib;
			r = '0;
			chars_taken++;
			case (phase)
				PH_HALT: begin
					return;
				end
				PH_WAIT: begin
					if (c != CHAR_COLON) begin
						r.kind = KIND_END;
						r.status = STATUS_NO_COLON;
						decoded_queue.push_back(r);
						phase = PH_HALT;
					end else begin
						high_nib = '0;
						have_high = 1'b0;
						hdr_idx = '0;
						rec_len = '0;
						rec_off = '0;
						rec_type = '0;
						line_sum = '0;
						data_idx = '0;
						word_hi = '0;
						word_lo = '0;
						phase = PH_HDR;
					end
					return;
				end
				PH_SKIP: begin
					if (c == CHAR_NEWLINE) begin
						phase = PH_WAIT;
					end
					return;
				end
				default: begin
				end
			endcase

			// pair up digits into a byte
			nib = digit_value(c);
			if (!have_high) begin
				high_nib = nib;
				have_high = 1'b1;
				return;
			end
			have_high = 1'b0;
			b = {high_nib, nib};
			line_sum = line_sum + b;

			// header fields
			if (phase == PH_HDR) begin
				case (hdr_idx)
					2'd0: rec_len = b;
					2'd1: rec_off[15:8] = b;
					2'd2: rec_off[7:0] = b;
					default: rec_type = b;
				endcase
				if (hdr_idx == 2'd3) begin
					hdr_idx = '0;
					phase = (rec_len != 8'd0) ? PH_DATA : PH_CSUM;
				end else begin
					hdr_idx = hdr_idx + 2'd1;
				end
				return;
			end

			r.record_type = rec_type;
			r.record_length = rec_len;
			r.record_offset = rec_off;

			// data byte with its absolute address
			if (phase == PH_DATA) begin
				r.kind = KIND_DATA;
				r.byte_value = b;
				r.byte_address = load_base + {16'h0000, rec_off} + {24'h000000, data_idx};
				if (data_idx == 8'd0) begin
					word_hi = b;
				end else if (data_idx == 8'd1) begin
					word_lo = b;
				end
				data_idx = data_idx + 8'd1;
				if (data_idx == rec_len) begin
					phase = PH_CSUM;
				end
				decoded_queue.push_back(r);
				return;
			end

			// checksum closes the record
			r.kind = KIND_END;
			phase = PH_SKIP;
			if (line_sum != 8'd0) begin
				r.status = STATUS_BAD_CSUM;
				phase = PH_HALT;
			end else if (rec_type == REC_EOF) begin
				r.end_of_file = 1'b1;
				phase = PH_HALT;
			end else if (rec_type == REC_EXT_SEG) begin
				load_base = {12'h000, word_hi, word_lo, 4'h0};
			end else if (rec_type == REC_EXT_LIN) begin
				load_base = {word_hi, word_lo, 16'h0000};
			end
			decoded_queue.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want) begin
				report($sformatf("result %0d %s got %0h expected %0h",
					bytes_seen + ends_seen, name, got, want));
			end
		endfunction

		// compare one accepted result with the oldest prediction
		function void match_result(result_t got);
			result_t want;
			if (decoded_queue.size() == 0) begin
				report($sformatf("unexpected result kind %0b status %0d",
					got.kind, got.status));
				return;
			end
			want = decoded_queue.pop_front();
			compare_field("kind", 32'(got.kind), 32'(want.kind));
			compare_field("byte_value", 32'(got.byte_value), 32'(want.byte_value));
			compare_field("byte_address", got.byte_address, want.byte_address);
			compare_field("record_type", 32'(got.record_type), 32'(want.record_type));
			compare_field("record_length", 32'(got.record_length), 32'(want.record_length));
			compare_field("record_offset", 32'(got.record_offset), 32'(want.record_offset));
			compare_field("status", 32'(got.status), 32'(want.status));
			compare_field("end_of_file", 32'(got.end_of_file), 32'(want.end_of_file));
			if (want.kind == KIND_DATA) begin
				bytes_seen++;
			end else begin
				ends_seen++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  character = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [7:0]  byte_value;
	logic [31:0] byte_address;
	logic [7:0]  record_type;
	logic [7:0]  record_length;
	logic [15:0] record_offset;
	logic [1:0]  status;
	logic        end_of_file;

	hex_decode_scoreboard sb;
	logic [7:0]  text_q[$];
	logic [7:0]  rec_bytes[$];
	logic [7:0]  line_sum;
	bit          odd_digits = 1'b0;
	int          idle_mode = IDLE_NONE;
	int unsigned record_count = 0;
	result_t     observed;

	hex_record_stream_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.character     (character),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.byte_value    (byte_value),
		.byte_address  (byte_address),
		.record_type   (record_type),
		.record_length (record_length),
		.record_offset (record_offset),
		.status        (status),
		.end_of_file   (end_of_file)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// pick a character for one digit, sometimes an unusual one
	function automatic logic [7:0] digit_char(logic [3:0] n);
		logic [7:0] c;
		if (odd_digits || $urandom_range(0, 99) < 20) begin
			do begin
				c = 8'($urandom_range(0, 255));
			end while (sb.digit_value(c) != n);
		end else begin
			c = (n < 4'd10) ? CHAR_ZERO + 8'(n) : CHAR_UPPER_A + 8'(n) - 8'd10;
		end
		return c;
	endfunction

	function automatic void put_byte(logic [7:0] b);
		text_q.push_back(digit_char(b[7:4]));
		text_q.push_back(digit_char(b[3:0]));
		line_sum = line_sum + b;
	endfunction

	// noise between a checksum and the newline
	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		if ($urandom_range(0, 1) == 0) begin
			return CHAR_RETURN;
		end
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == CHAR_NEWLINE);
		return c;
	endfunction

	// one full record line; data beyond rec_bytes is random
	function automatic void put_record(logic [7:0] len, logic [15:0] off, logic [7:0] rtype,
		bit bad_sum, int unsigned junk);
		logic [7:0]  b;
		int unsigned i;
		text_q.push_back(CHAR_COLON);
		line_sum = 8'h00;
		put_byte(len);
		put_byte(off[15:8]);
		put_byte(off[7:0]);
		put_byte(rtype);
		for (i = 0; i < len; i++) begin
			b = (i < rec_bytes.size()) ? rec_bytes[i] : 8'($urandom_range(0, 255));
			put_byte(b);
		end
		b = 8'h00 - line_sum;
		if (bad_sum) begin
			b = b + 8'($urandom_range(1, 255));
		end
		put_byte(b);
		for (i = 0; i < junk; i++) begin
			text_q.push_back(junk_char());
		end
		text_q.push_back(CHAR_NEWLINE);
		rec_bytes.delete();
		record_count++;
	endfunction

	// random record stream with valid checksums
	task automatic build_random_records();
		logic [7:0]  rtype;
		logic [7:0]  len;
		int unsigned pick;
		int unsigned junk;
		while (text_q.size() < 2000) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				rtype = REC_DATA;
			end else if (pick < 80) begin
				rtype = REC_EXT_SEG;
			end else if (pick < 90) begin
				rtype = REC_EXT_LIN;
			end else if (pick < 94) begin
				rtype = REC_START_SEG;
			end else if (pick < 97) begin
				rtype = REC_START_LIN;
			end else begin
				rtype = 8'($urandom_range(6, 255));
			end
			pick = $urandom_range(0, 99);
			if (rtype == REC_EXT_SEG || rtype == REC_EXT_LIN) begin
				len = (pick < 75) ? 8'd2 : 8'($urandom_range(0, 4));
			end else if (pick < 2) begin
				len = 8'($urandom_range(65, 255));
			end else if (pick < 15) begin
				len = 8'($urandom_range(17, 64));
			end else begin
				len = 8'($urandom_range(0, 16));
			end
			pick = $urandom_range(0, 99);
			junk = (pick < 60) ? 0 : (pick < 85) ? 1 : $urandom_range(2, 6);
			put_record(len, 16'($urandom_range(0, 65535)), rtype, 1'b0, junk);
		end
	endtask

	// send every character, gaps drawn from the current idle scheme
	task automatic send_text();
		int unsigned idx;
		int unsigned gap_pct;
		for (idx = 0; idx < text_q.size(); idx++) begin
			idle_mode = (idx / 250) % 4;
			gap_pct = (idle_mode == IDLE_SEND) ? 63 : (idle_mode == IDLE_BOTH) ? 15 : 0;
			while ($urandom_range(0, 99) < gap_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			character <= text_q[idx];
			do begin
				@(posedge clk);
			end while (in_stall);
			sb.take_character(text_q[idx]);
		end
		in_valid <= 1'b0;
	endtask

	// result side: check accepted results, draw the next stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				observed = {kind, byte_value, byte_address, record_type, record_length,
					record_offset, status, end_of_file};
				sb.match_result(observed);
			end
			out_stall <= ($urandom_range(0, 99) <
				((idle_mode == IDLE_RECV) ? 63 : (idle_mode == IDLE_BOTH) ? 15 : 0));
		end
	end

	initial begin
		int    closing;
		string closing_name;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed records
		put_record(8'd0, 16'h0000, REC_DATA, 1'b0, 0);
		rec_bytes = '{8'hFF, 8'hFF};
		put_record(8'd2, 16'h0000, REC_EXT_LIN, 1'b0, 1);
		// address wraps past the top of the space
		rec_bytes = '{8'h00, 8'hFF};
		put_record(8'd2, 16'hFFFF, REC_DATA, 1'b0, 2);
		// short segment record, unusual digit characters throughout
		odd_digits = 1'b1;
		rec_bytes = '{8'h12};
		put_record(8'd1, 16'h8001, REC_EXT_SEG, 1'b0, 3);
		odd_digits = 1'b0;
		put_record(8'd3, 16'h0010, REC_START_SEG, 1'b0, 0);
		put_record(8'd4, 16'h1234, REC_START_LIN, 1'b0, 0);
		put_record(8'd1, 16'h7FFF, REC_UNKNOWN, 1'b0, 1);
		put_record(8'd0, 16'h0000, REC_EXT_LIN, 1'b0, 0);
		rec_bytes = '{8'hAB, 8'hCD, 8'hEF};
		put_record(8'd3, 16'h0000, REC_EXT_SEG, 1'b0, 0);
		put_record(8'hFF, 16'hFFFF, REC_DATA, 1'b0, 1);

		build_random_records();

		// one halting case closes the stream
		closing = $urandom_range(0, 2);
		case (closing)
			CLOSE_NO_COLON: begin
				closing_name = "missing start colon";
				text_q.push_back(8'(CHAR_COLON + 8'($urandom_range(1, 255))));
			end
			CLOSE_BAD_CSUM: begin
				closing_name = "checksum mismatch";
				put_record(8'($urandom_range(0, 4)), 16'($urandom_range(0, 65535)),
					($urandom_range(0, 1) == 0) ? REC_EOF : REC_DATA, 1'b1, 0);
			end
			default: begin
				closing_name = "end of file";
				put_record(8'($urandom_range(0, 2)), 16'($urandom_range(0, 65535)),
					REC_EOF, 1'b0, 0);
			end
		endcase
		// a halted block must ignore whatever follows
		put_record(8'd2, 16'h0100, REC_DATA, 1'b0, 1);
		repeat (6) text_q.push_back(8'($urandom_range(0, 255)));

		send_text();
		while (sb.decoded_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d characters in %0d records: %0d data bytes, %0d record ends",
			sb.chars_taken, record_count, sb.bytes_seen, sb.ends_seen);
		$display("stream closed by %s, %0d mismatches", closing_name, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", sb.decoded_queue.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
